>>> rtl/tcw_pkg.sv
// Shared types, constants and helpers of the text console writer.
// Used by text_console_writer; depends on nothing else.
package tcw_pkg;

    localparam int MAX_COLS    = 80;
    localparam int MAX_ROWS    = 25;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int COLS_W   = 7;
    localparam int ROWS_W   = 5;
    localparam int COLOR_W  = 4;
    localparam int NUM_REGS = 6;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);
    localparam int PDATA_W  = 32;

    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(25);
    localparam logic [COLS_W-1:0] COLS_MAX   = COLS_W'(MAX_COLS);
    localparam logic [ROWS_W-1:0] ROWS_MAX   = ROWS_W'(MAX_ROWS);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_COLUMNS  = 3'd0,
        REG_ROWS     = 3'd1,
        REG_TEXT_FG  = 3'd2,
        REG_TEXT_BG  = 3'd3,
        REG_BLANK_FG = 3'd4,
        REG_BLANK_BG = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_PUT_APPLY,
        ST_CLEAR,
        ST_RD_WAIT,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         char_code;
        logic [7:0]         cell_column;
        logic [7:0]         cell_row;
        logic [COLOR_W-1:0] cell_fg;
        logic [COLOR_W-1:0] cell_bg;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] cursor_position;
        logic [15:0] cell_data;
        logic        did_scroll;
    } rsp_word_t;

    function automatic logic [15:0] make_cell(input logic [7:0] ch,
                                              input logic [COLOR_W-1:0] fg,
                                              input logic [COLOR_W-1:0] bg);
        return {bg, fg, ch};
    endfunction

    // Linear store address of cell (col, row); caller keeps both in range.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] row,
                                                    input logic [7:0] col);
        logic [15:0] lin;
        lin = 16'(row) * 16'(MAX_COLS) + 16'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/text_console_writer.sv
// Text console writer: cell store, cursor, sequencer for scroll and clear.
// Depends on tcw_pkg.
//
//  channel | signals                          | direction | payload
//  cmd     | cmd_valid, cmd_stall, cmd        | in        | tcw_pkg::cmd_word_t
//  rsp     | rsp_valid, rsp_stall, rsp        | out       | tcw_pkg::rsp_word_t
//  apb     | psel penable pwrite paddr pwdata | in        | config registers
//          | prdata pready                    | out       |
//
// A plain put passes the decode and apply states, an in-window read the decode
// and read-wait states, before the done state loads the result into the output
// register; the next command is taken back in idle. Write cell and a read
// outside the window skip the middle state. A scroll copies each cell through a
// read and a write state, then blanks the last row, all through the single
// store port pair. Clear sweeps all 2000 cells at one per cycle. cmd_stall is
// high whenever the sequencer is busy; a finished word waits in the output
// register while the next command is taken. Reset clears cursor and valid and
// sets the registers to their defaults; the store holds garbage until written.
module text_console_writer
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  tcw_pkg::cmd_word_t            cmd,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output tcw_pkg::rsp_word_t            rsp,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    tcw_pkg::fsm_state_t state_reg, state_next;

    logic [7:0]                   cursor_col_reg, cursor_col_next;
    logic [7:0]                   cursor_row_reg, cursor_row_next;
    logic [tcw_pkg::COLS_W-1:0]   columns_reg;
    logic [tcw_pkg::ROWS_W-1:0]   rows_reg;
    logic [tcw_pkg::COLOR_W-1:0]  text_fg_reg, text_bg_reg;
    logic [tcw_pkg::COLOR_W-1:0]  blank_fg_reg, blank_bg_reg;
    logic                         rsp_valid_reg, rsp_valid_next;

    tcw_pkg::cmd_word_t           cmd_reg;
    tcw_pkg::rsp_word_t           rsp_reg, rsp_next;
    logic [15:0]                  cell_data_reg, cell_data_next;
    logic                         scrolled_reg, scrolled_next;
    logic [tcw_pkg::COLS_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [tcw_pkg::ROWS_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [tcw_pkg::ADDR_W-1:0]   row_base_reg, row_base_next;
    logic [tcw_pkg::ADDR_W-1:0]   clr_addr_reg, clr_addr_next;

    logic [15:0]                  store_mem [0:tcw_pkg::STORE_DEPTH-1];
    logic [15:0]                  mem_rdata;
    logic                         mem_we, mem_re;
    logic [tcw_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [15:0]                  mem_wdata;

    logic [tcw_pkg::COLS_W-1:0]   eff_w;
    logic [tcw_pkg::ROWS_W-1:0]   eff_h;
    logic                         cmd_take, rsp_load, cfg_we;
    logic                         col_wrap, do_scroll, in_window;
    logic [7:0]                   row_wrapped;
    logic                         row_last_col, copy_last_row, clr_last;
    logic [14:0]                  pos_prod;
    logic [15:0]                  blank_cell;

    // Saturate the visible window to the store size; a zero width or height counts as one.
    always_comb
    begin
        if (columns_reg == '0)
            eff_w = tcw_pkg::COLS_W'(1);
        else if (columns_reg > tcw_pkg::COLS_MAX)
            eff_w = tcw_pkg::COLS_MAX;
        else
            eff_w = columns_reg;

        if (rows_reg == '0)
            eff_h = tcw_pkg::ROWS_W'(1);
        else if (rows_reg > tcw_pkg::ROWS_MAX)
            eff_h = tcw_pkg::ROWS_MAX;
        else
            eff_h = rows_reg;
    end

    assign cmd_stall = (state_reg != tcw_pkg::ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign rsp_load  = (state_reg == tcw_pkg::ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign col_wrap    = (cursor_col_reg >= 8'(eff_w));
    assign row_wrapped = col_wrap ? cursor_row_reg + 8'd1 : cursor_row_reg;
    assign do_scroll   = (row_wrapped >= 8'(eff_h));
    assign in_window   = (cmd_reg.cell_column < 8'(eff_w)) && (cmd_reg.cell_row < 8'(eff_h));

    assign row_last_col  = (col_cnt_reg == eff_w - tcw_pkg::COLS_W'(1));
    assign copy_last_row = (row_cnt_reg + tcw_pkg::ROWS_W'(1) == eff_h - tcw_pkg::ROWS_W'(1));
    assign clr_last      = (clr_addr_reg == tcw_pkg::ADDR_W'(tcw_pkg::STORE_DEPTH - 1));

    assign pos_prod   = 15'(cursor_row_reg) * 15'(eff_w);
    assign blank_cell = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, blank_fg_reg, blank_bg_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (cmd_take)
                    state_next = tcw_pkg::ST_DECODE;
            end
            tcw_pkg::ST_DECODE:
            begin
                case (tcw_pkg::opcode_t'(cmd_reg.opcode))
                    tcw_pkg::OP_PUT:
                    begin
                        if (!do_scroll)
                            state_next = tcw_pkg::ST_PUT_APPLY;
                        else if (eff_h == tcw_pkg::ROWS_W'(1))
                            state_next = tcw_pkg::ST_BLANK;
                        else
                            state_next = tcw_pkg::ST_SCR_RD;
                    end
                    tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                    tcw_pkg::OP_READ:  state_next = in_window ? tcw_pkg::ST_RD_WAIT
                                                              : tcw_pkg::ST_DONE;
                    default:           state_next = tcw_pkg::ST_DONE;
                endcase
            end
            tcw_pkg::ST_SCR_RD:
                state_next = tcw_pkg::ST_SCR_WR;
            tcw_pkg::ST_SCR_WR:
            begin
                if (row_last_col && copy_last_row)
                    state_next = tcw_pkg::ST_BLANK;
                else
                    state_next = tcw_pkg::ST_SCR_RD;
            end
            tcw_pkg::ST_BLANK:
            begin
                if (row_last_col)
                    state_next = tcw_pkg::ST_PUT_APPLY;
            end
            tcw_pkg::ST_PUT_APPLY:
                state_next = tcw_pkg::ST_DONE;
            tcw_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_RD_WAIT:
                state_next = tcw_pkg::ST_DONE;
            tcw_pkg::ST_DONE:
            begin
                if (rsp_load)
                    state_next = tcw_pkg::ST_IDLE;
            end
            default:
                state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        cell_data_next  = cell_data_reg;
        scrolled_next   = scrolled_reg;
        col_cnt_next    = col_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        row_base_next   = row_base_reg;
        clr_addr_next   = clr_addr_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = row_base_reg + tcw_pkg::ADDR_W'(col_cnt_reg);
        mem_wdata       = blank_cell;
        mem_re          = 1'b0;
        mem_raddr       = row_base_reg + tcw_pkg::ADDR_W'(tcw_pkg::MAX_COLS)
                          + tcw_pkg::ADDR_W'(col_cnt_reg);

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            tcw_pkg::ST_DECODE:
            begin
                cell_data_next = '0;
                scrolled_next  = 1'b0;
                col_cnt_next   = '0;
                row_cnt_next   = '0;
                row_base_next  = '0;
                clr_addr_next  = '0;
                case (tcw_pkg::opcode_t'(cmd_reg.opcode))
                    tcw_pkg::OP_PUT:
                    begin
                        if (col_wrap)
                            cursor_col_next = '0;
                        cursor_row_next = row_wrapped;
                        scrolled_next   = do_scroll;
                    end
                    tcw_pkg::OP_WRITE:
                    begin
                        mem_we    = in_window;
                        mem_waddr = tcw_pkg::cell_addr(cmd_reg.cell_row, cmd_reg.cell_column);
                        mem_wdata = tcw_pkg::make_cell(cmd_reg.char_code, cmd_reg.cell_fg,
                                                       cmd_reg.cell_bg);
                    end
                    tcw_pkg::OP_READ:
                    begin
                        mem_re    = in_window;
                        mem_raddr = tcw_pkg::cell_addr(cmd_reg.cell_row, cmd_reg.cell_column);
                    end
                    default:
                    begin
                    end
                endcase
            end
            tcw_pkg::ST_SCR_RD:
                mem_re = 1'b1;
            tcw_pkg::ST_SCR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (row_last_col)
                begin
                    col_cnt_next  = '0;
                    row_cnt_next  = row_cnt_reg + tcw_pkg::ROWS_W'(1);
                    row_base_next = row_base_reg + tcw_pkg::ADDR_W'(tcw_pkg::MAX_COLS);
                end
                else
                    col_cnt_next = col_cnt_reg + tcw_pkg::COLS_W'(1);
            end
            tcw_pkg::ST_BLANK:
            begin
                mem_we = 1'b1;
                col_cnt_next = col_cnt_reg + tcw_pkg::COLS_W'(1);
                if (row_last_col)
                    cursor_row_next = 8'(eff_h - tcw_pkg::ROWS_W'(1));
            end
            tcw_pkg::ST_PUT_APPLY:
            begin
                if (cmd_reg.char_code == tcw_pkg::CH_NEWLINE)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = cursor_row_reg + 8'd1;
                end
                else if (cmd_reg.char_code == tcw_pkg::CH_RETURN)
                    cursor_col_next = '0;
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = tcw_pkg::cell_addr(cursor_row_reg, cursor_col_reg);
                    mem_wdata       = tcw_pkg::make_cell(cmd_reg.char_code, text_fg_reg,
                                                         text_bg_reg);
                    cursor_col_next = cursor_col_reg + 8'd1;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + tcw_pkg::ADDR_W'(1);
                if (clr_last)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = '0;
                end
            end
            tcw_pkg::ST_RD_WAIT:
                cell_data_next = mem_rdata;
            tcw_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_next.cursor_position = 16'(pos_prod) + 16'(cursor_col_reg);
                    rsp_next.cell_data       = cell_data_reg;
                    rsp_next.did_scroll      = scrolled_reg;
                    rsp_valid_next           = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        case (tcw_pkg::reg_index_t'(paddr[tcw_pkg::PADDR_W-1:2]))
            tcw_pkg::REG_COLUMNS:  prdata = tcw_pkg::PDATA_W'(columns_reg);
            tcw_pkg::REG_ROWS:     prdata = tcw_pkg::PDATA_W'(rows_reg);
            tcw_pkg::REG_TEXT_FG:  prdata = tcw_pkg::PDATA_W'(text_fg_reg);
            tcw_pkg::REG_TEXT_BG:  prdata = tcw_pkg::PDATA_W'(text_bg_reg);
            tcw_pkg::REG_BLANK_FG: prdata = tcw_pkg::PDATA_W'(blank_fg_reg);
            tcw_pkg::REG_BLANK_BG: prdata = tcw_pkg::PDATA_W'(blank_bg_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcw_pkg::ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            columns_reg    <= tcw_pkg::COLS_RESET;
            rows_reg       <= tcw_pkg::ROWS_RESET;
            text_fg_reg    <= tcw_pkg::COLOR_W'(3);
            text_bg_reg    <= '0;
            blank_fg_reg   <= tcw_pkg::COLOR_W'(3);
            blank_bg_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_we)
            begin
                case (tcw_pkg::reg_index_t'(paddr[tcw_pkg::PADDR_W-1:2]))
                    tcw_pkg::REG_COLUMNS:  columns_reg  <= pwdata[tcw_pkg::COLS_W-1:0];
                    tcw_pkg::REG_ROWS:     rows_reg     <= pwdata[tcw_pkg::ROWS_W-1:0];
                    tcw_pkg::REG_TEXT_FG:  text_fg_reg  <= pwdata[tcw_pkg::COLOR_W-1:0];
                    tcw_pkg::REG_TEXT_BG:  text_bg_reg  <= pwdata[tcw_pkg::COLOR_W-1:0];
                    tcw_pkg::REG_BLANK_FG: blank_fg_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
                    tcw_pkg::REG_BLANK_BG: blank_bg_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_reg <= cmd;
        rsp_reg       <= rsp_next;
        cell_data_reg <= cell_data_next;
        scrolled_reg  <= scrolled_next;
        col_cnt_reg   <= col_cnt_next;
        row_cnt_reg   <= row_cnt_next;
        row_base_reg  <= row_base_next;
        clr_addr_reg  <= clr_addr_next;
    end

    // Cell store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata <= store_mem[mem_raddr];
    end

endmodule
